// ----- rtl/skt_pkg.sv -----
// shared types and codes for the sorted keyed table
package skt_pkg;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // status codes
   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_DELETED   = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_READ_OK   = 3'd5;
   localparam logic [2:0] ST_BAD_INDEX = 3'd6;

   // widest position that a cell can be told (table of up to 1024 entries)
   localparam int AT_W = 10;

   typedef struct packed {
      logic [1:0]         operation;
      logic [63:0]        name_key;
      logic signed [31:0] score_in;
      logic [5:0]         read_index;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [5:0]         position;
      logic [63:0]        out_name_key;
      logic signed [31:0] out_score;
      logic [6:0]         entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      MODE_HOLD,
      MODE_INSERT,
      MODE_DELETE
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type   mode;
      logic [AT_W-1:0] at;
   } cell_ctrl_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

endpackage

// ----- rtl/skt_cell.sv -----
// one table slot: holds an entry, compares it with the request, shifts with its neighbours
module skt_cell #(
   parameter int IDX = 0,
   parameter int CW  = 7
) (
   input  logic                   clock,
   input  logic [CW-1:0]          count,
   input  logic [63:0]            req_key,
   input  logic signed [31:0]     req_score,
   input  logic [63:0]            left_key,
   input  logic signed [31:0]     left_score,
   input  logic                   left_ahead,
   input  logic [63:0]            right_key,
   input  logic signed [31:0]     right_score,
   input  skt_pkg::cell_ctrl_type ctrl,
   output logic [63:0]            key,
   output logic signed [31:0]     score,
   output logic                   ahead,
   output logic                   hit
);
   import skt_pkg::*;

   logic [63:0]        key_ff,   key_in;
   logic signed [31:0] score_ff, score_in;
   logic               slot_valid;

   // slot holds a live entry when it lies below the fill count
   assign slot_valid = CW'(IDX) < count;
   assign ahead      = slot_valid && (score_ff > req_score);
   assign hit        = slot_valid && (key_ff == req_key);
   assign key        = key_ff;
   assign score      = score_ff;

   // shift or load the slot
   always_comb begin
      key_in   = key_ff;
      score_in = score_ff;
      unique case (ctrl.mode)
         MODE_HOLD: begin
         end
         MODE_INSERT: begin
            if (!ahead) begin
               if (left_ahead) begin
                  key_in   = req_key;
                  score_in = req_score;
               end else begin
                  key_in   = left_key;
                  score_in = left_score;
               end
            end
         end
         MODE_DELETE: begin
            if (AT_W'(IDX) >= ctrl.at) begin
               key_in   = right_key;
               score_in = right_score;
            end
         end
         default: begin
         end
      endcase
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      score_ff <= score_in;
   end

endmodule

// ----- rtl/sorted_keyed_table_top.sv -----
// top level of the sorted keyed table: request register, control and the row of cells
// a request beat is taken into the request register and its response is registered
// in the execute state; no new request is taken until that state is left. The row of
// cells compares every slot and shifts in the execute state, after the request register
// a response that is stalled holds the next request in the execute state
// reset (synchronous) empties the table and clears the handshakes; slots are not cleared
module sorted_keyed_table_top #(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  skt_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output skt_pkg::rsp_type rsp
);
   import skt_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int WW = CW + 7;

   state_type     state_ff, state_in;
   req_type       req_ff;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] count_ff, count_in;
   logic          exec;
   cell_ctrl_type ctrl;

   logic [63:0]        cell_key   [DEPTH];
   logic signed [31:0] cell_score [DEPTH];
   logic [DEPTH-1:0]   cell_ahead;
   logic [DEPTH-1:0]   cell_hit;

   logic               any_hit;
   logic [IW-1:0]      hit_pos;
   logic [IW-1:0]      ins_pos;
   logic [63:0]        rd_key;
   logic signed [31:0] rd_score;
   logic [WW-1:0]      ridx_w;
   logic [WW-1:0]      count_w;
   logic               rd_ok;
   logic               full;
   logic [IW-1:0]      pos;
   logic [IW+5:0]      pos_w;
   logic [WW-1:0]      count_out_w;

   // control sequence: idle takes a beat, execute commits when the response slot frees
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_EXEC;
         S_EXEC: if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      exec      = 1'b0;
      unique case (state_ff)
         S_IDLE: req_stall = 1'b0;
         S_EXEC: exec = !rsp_valid_ff || !rsp_stall;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         req_ff <= req;
      end
   end

   // row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [63:0]        l_key, r_key;
      logic signed [31:0] l_score, r_score;
      logic               l_ahead;
      if (i == 0) begin : g_first
         assign l_key   = '0;
         assign l_score = '0;
         assign l_ahead = 1'b1;
      end else begin : g_mid
         assign l_key   = cell_key[i-1];
         assign l_score = cell_score[i-1];
         assign l_ahead = cell_ahead[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign r_key   = '0;
         assign r_score = '0;
      end else begin : g_inner
         assign r_key   = cell_key[i+1];
         assign r_score = cell_score[i+1];
      end
      skt_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock       (clock),
         .count       (count_ff),
         .req_key     (req_ff.name_key),
         .req_score   (req_ff.score_in),
         .left_key    (l_key),
         .left_score  (l_score),
         .left_ahead  (l_ahead),
         .right_key   (r_key),
         .right_score (r_score),
         .ctrl        (ctrl),
         .key         (cell_key[i]),
         .score       (cell_score[i]),
         .ahead       (cell_ahead[i]),
         .hit         (cell_hit[i])
      );
   end

   // gather one-hot flags from the row: match, insert boundary, read select
   assign ridx_w  = WW'(req_ff.read_index);
   assign count_w = WW'(count_ff);
   always_comb begin
      any_hit  = 1'b0;
      hit_pos  = '0;
      ins_pos  = '0;
      rd_key   = '0;
      rd_score = '0;
      for (int i = 0; i < DEPTH; i++) begin
         any_hit = any_hit | cell_hit[i];
         if (cell_hit[i]) hit_pos = hit_pos | IW'(i);
         if (!cell_ahead[i] && ((i == 0) || cell_ahead[(i == 0) ? 0 : i - 1])) begin
            ins_pos = ins_pos | IW'(i);
         end
         if (ridx_w == WW'(i)) begin
            rd_key   = rd_key | cell_key[i];
            rd_score = rd_score | cell_score[i];
         end
      end
   end

   assign full  = count_ff == CW'(DEPTH);
   assign rd_ok = (ridx_w < count_w) && (ridx_w < WW'(DEPTH));

   // decision for the request
   always_comb begin
      ctrl.mode           = MODE_HOLD;
      ctrl.at             = '0;
      count_in            = count_ff;
      pos                 = '0;
      rsp_in.status       = ST_BAD_INDEX;
      rsp_in.out_name_key = '0;
      rsp_in.out_score    = '0;
      unique case (req_ff.operation)
         OP_INSERT: begin
            if (any_hit) begin
               rsp_in.status = ST_DUPLICATE;
               pos           = hit_pos;
            end else if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               rsp_in.status = ST_INSERTED;
               pos           = ins_pos;
               ctrl.mode     = exec ? MODE_INSERT : MODE_HOLD;
               count_in      = count_ff + CW'(1);
            end
         end
         OP_DELETE: begin
            if (!any_hit) begin
               rsp_in.status = ST_NOT_FOUND;
            end else begin
               rsp_in.status = ST_DELETED;
               pos           = hit_pos;
               ctrl.mode     = exec ? MODE_DELETE : MODE_HOLD;
               ctrl.at       = AT_W'(hit_pos);
               count_in      = count_ff - CW'(1);
            end
         end
         OP_READ: begin
            if (rd_ok) begin
               rsp_in.status       = ST_READ_OK;
               pos                 = IW'(req_ff.read_index);
               rsp_in.out_name_key = rd_key;
               rsp_in.out_score    = rd_score;
            end
         end
         default: begin
         end
      endcase
      pos_w              = (IW + 6)'(pos);
      count_out_w        = WW'(count_in);
      rsp_in.position    = pos_w[5:0];
      rsp_in.entry_count = count_out_w[6:0];
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (exec) begin
         count_ff <= count_in;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- rtl/skt_checker.sv -----
// port checker for the sorted keyed table, bound to the top level
module skt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input skt_pkg::req_type req,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input skt_pkg::rsp_type rsp
);
   import skt_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled response beat changed");

   // no status code beyond bad index
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.status <= ST_BAD_INDEX)
      else $error("undefined status code");

   // refusals report position zero
   a_refusal_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_NOT_FOUND
                    || rsp.status == ST_BAD_INDEX) |-> rsp.position == '0)
      else $error("refusal with nonzero position");

   // entry data only on a good read
   a_read_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != ST_READ_OK |-> rsp.out_name_key == '0 && rsp.out_score == '0)
      else $error("entry data outside a read");

   // a request beat is never taken while the previous one is still in execute
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken during execute");

endmodule

bind sorted_keyed_table_top skt_checker u_skt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

// ----- bench/tb_sorted_keyed_table_top.sv -----
// self-checking bench for the sorted keyed table: random and directed beats against a predictor
`timescale 1ns / 1ps

module tb_sorted_keyed_table_top;
   import skt_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int RANDOM_ITEMS = 1800;
   localparam int IDLE_PCT     = 25;
   localparam int DRAIN_CYCLES = 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   // request beats still to send and responses still owed
   req_type pending_beats[$];
   rsp_type owed_responses[$];
   logic [63:0] key_pool[$];

   // shadow copy of the table
   logic [63:0]        table_keys[TABLE_DEPTH];
   logic signed [31:0] table_scores[TABLE_DEPTH];
   int                 table_count = 0;

   logic req_taken = 1'b0;
   int   cycle_count = 0;
   int   mismatch_count = 0;

   sorted_keyed_table_top #(
      .DEPTH(TABLE_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req      (req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp      (rsp)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // work out the response to one beat and move the shadow table on
   task automatic predict_table_op(input req_type beat, output rsp_type answer);
      int hit;
      int at;
      hit = -1;
      at = 0;
      answer = '0;
      answer.status = ST_BAD_INDEX;
      for (int i = 0; i < table_count; i++) begin
         if (hit < 0 && table_keys[i] == beat.name_key) hit = i;
      end
      case (beat.operation)
         OP_INSERT: begin
            if (hit >= 0) begin
               answer.status = ST_DUPLICATE;
               at = hit;
            end else if (table_count >= TABLE_DEPTH) begin
               answer.status = ST_FULL;
            end else begin
               // new entry goes ahead of its ties
               while (at < table_count && table_scores[at] > $signed(beat.score_in)) at++;
               for (int i = table_count; i > at; i--) begin
                  table_keys[i]   = table_keys[i-1];
                  table_scores[i] = table_scores[i-1];
               end
               table_keys[at]   = beat.name_key;
               table_scores[at] = beat.score_in;
               table_count++;
               answer.status = ST_INSERTED;
            end
         end
         OP_DELETE: begin
            if (hit < 0) begin
               answer.status = ST_NOT_FOUND;
            end else begin
               at = hit;
               for (int i = hit; i + 1 < table_count; i++) begin
                  table_keys[i]   = table_keys[i+1];
                  table_scores[i] = table_scores[i+1];
               end
               table_count--;
               answer.status = ST_DELETED;
            end
         end
         OP_READ: begin
            if (int'(beat.read_index) < table_count) begin
               answer.status       = ST_READ_OK;
               at                  = int'(beat.read_index);
               answer.out_name_key = table_keys[at];
               answer.out_score    = table_scores[at];
            end
         end
         default: begin
         end
      endcase
      answer.position    = at[5:0];
      answer.entry_count = table_count[6:0];
   endtask

   task automatic report_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
      if (want !== got) begin
         $display("%0t %s expected %h actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   task automatic queue_beat(input logic [1:0] op, input logic [63:0] key,
                             input logic [31:0] score, input logic [5:0] idx);
      req_type beat;
      beat.operation  = op;
      beat.name_key   = key;
      beat.score_in   = score;
      beat.read_index = idx;
      pending_beats.push_back(beat);
      if (op == OP_INSERT) begin
         key_pool.push_back(key);
         if (key_pool.size() > 128) void'(key_pool.pop_front());
      end
   endtask

   function automatic logic [63:0] fresh_key();
      if ($urandom_range(0, 7) == 0) return 64'($urandom_range(0, 7));
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pool_key();
      if (key_pool.size() == 0) return fresh_key();
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
   endfunction

   // extremes, narrow band for ties, or anything
   function automatic logic [31:0] pick_score();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3: return 32'hffff_ffff;
         4, 5, 6: return 32'($signed($urandom_range(0, 6)) - 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic int table_count_hint();
      return (key_pool.size() > 63) ? 63 : key_pool.size();
   endfunction

   function automatic logic [5:0] pick_index();
      if ($urandom_range(0, 3) == 0) return 6'($urandom_range(0, 63));
      return 6'($urandom_range(0, table_count_hint()));
   endfunction

   // sample the request side: every taken beat gets its prediction
   always @(posedge clock) begin
      rsp_type answer;
      cycle_count <= cycle_count + 1;
      if (!reset && req_valid && req_stall === 1'b0) begin
         predict_table_op(req, answer);
         owed_responses.push_back(answer);
         req_taken <= 1'b1;
      end else begin
         req_taken <= 1'b0;
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (owed_responses.size() == 0) begin
            $display("%0t unexpected response expected none actual %h", $time, rsp);
            mismatch_count++;
         end else begin
            want = owed_responses.pop_front();
            report_field("status", 64'(want.status), 64'(rsp.status));
            report_field("position", 64'(want.position), 64'(rsp.position));
            report_field("out_name_key", want.out_name_key, rsp.out_name_key);
            report_field("out_score", 64'(want.out_score), 64'(rsp.out_score));
            report_field("entry_count", 64'(want.entry_count), 64'(rsp.entry_count));
         end
      end
   end

   // request driver, idles at random outside the quiet window
   always @(negedge clock) begin
      logic quiet;
      quiet = (cycle_count >= 2000 && cycle_count < 3500);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_beats.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req       <= pending_beats.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (cycle_count >= 2000 && cycle_count < 3500) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   initial begin
      int fill_len;
      int drain_len;
      int pick;
      int random_start;

      // directed: empty table, ordering and ties, duplicate, bounds
      queue_beat(OP_READ, 64'h0, 32'h0, 6'd0);
      queue_beat(OP_DELETE, 64'h0, 32'h0, 6'd0);
      queue_beat(OP_UNUSED, '1, '1, '1);
      queue_beat(OP_INSERT, 64'h0, 32'h0, 6'd0);
      queue_beat(OP_INSERT, '1, 32'h7fff_ffff, 6'd0);
      queue_beat(OP_INSERT, 64'h5555_5555_5555_5555, 32'h8000_0000, 6'd0);
      queue_beat(OP_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 32'h0, 6'h2a);
      queue_beat(OP_INSERT, 64'h0, 32'h7fff_ffff, 6'd0);
      queue_beat(OP_READ, 64'h0, 32'h0, 6'd0);
      queue_beat(OP_READ, 64'h0, 32'h0, 6'd1);
      queue_beat(OP_READ, 64'h0, 32'h0, 6'd2);
      queue_beat(OP_READ, 64'h0, 32'h0, 6'd3);
      queue_beat(OP_READ, 64'h0, 32'h0, 6'd4);
      queue_beat(OP_READ, '1, '1, 6'd63);
      queue_beat(OP_DELETE, '1, 32'h0, 6'd0);
      queue_beat(OP_DELETE, 64'h0, 32'h0, 6'd0);
      queue_beat(OP_DELETE, 64'h1234_5678_9abc_def0, 32'h0, 6'd0);
      queue_beat(OP_READ, 64'h0, 32'h0, 6'd0);
      queue_beat(OP_UNUSED, 64'h0, 32'h0, 6'd0);

      // random rounds: a filling phase that often hits full, then a draining phase
      random_start = pending_beats.size();
      while (pending_beats.size() - random_start < RANDOM_ITEMS) begin
         fill_len = $urandom_range(40, 130);
         for (int n = 0; n < fill_len; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               queue_beat(OP_INSERT, fresh_key(), pick_score(), 6'($urandom));
            end else if (pick < 88) begin
               queue_beat(OP_INSERT, pool_key(), pick_score(), 6'($urandom));
            end else if (pick < 95) begin
               queue_beat(OP_READ, 64'($urandom), $urandom, pick_index());
            end else if (pick < 97) begin
               queue_beat(OP_DELETE, pool_key(), $urandom, 6'($urandom));
            end else begin
               queue_beat(2'($urandom), {$urandom, $urandom}, $urandom, 6'($urandom));
            end
         end
         drain_len = $urandom_range(30, 110);
         for (int n = 0; n < drain_len; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               queue_beat(OP_DELETE, pool_key(), $urandom, 6'($urandom));
            end else if (pick < 70) begin
               queue_beat(OP_DELETE, fresh_key(), $urandom, 6'($urandom));
            end else if (pick < 85) begin
               queue_beat(OP_READ, 64'($urandom), $urandom, pick_index());
            end else if (pick < 97) begin
               queue_beat(OP_INSERT, fresh_key(), pick_score(), 6'($urandom));
            end else begin
               queue_beat(OP_UNUSED, {$urandom, $urandom}, $urandom, 6'($urandom));
            end
         end
      end

      // single reset at the start
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for every beat to go out and every response to come back
      while (pending_beats.size() != 0 || req_valid || owed_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- sorted_keyed_table_top.f -----
rtl/skt_pkg.sv
rtl/skt_cell.sv
rtl/sorted_keyed_table_top.sv
rtl/skt_checker.sv
bench/tb_sorted_keyed_table_top.sv
